// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the BAR sizing sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checks a property at every rising clock edge outside of reset.
`define PBS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Checks that a condition never holds outside of reset.
`define PBS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define PBS_ASSERT(lbl, clk, rst_n, prop)
`define PBS_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== rtl/pbs_pkg.sv =====
// ----------------------------------------------------------------------------
// BAR sizing sequencer package
// Types, codes and result builders shared by the sequencer modules.
// ----------------------------------------------------------------------------
package pbs_pkg;

  localparam int unsigned NumSlots = 6;
  localparam int unsigned MaxRes   = 3;
  localparam logic [7:0]  BarBase  = 8'h10;

  typedef enum logic [0:0] {
    KIND_START = 1'b0,
    KIND_RESP  = 1'b1
  } in_kind_e;

  typedef enum logic [1:0] {
    RES_READ   = 2'd0,
    RES_WRITE  = 2'd1,
    RES_RECORD = 2'd2,
    RES_DONE   = 2'd3
  } res_kind_e;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_ORIG    = 5'b00010,
    PH_BACK    = 5'b00100,
    PH_ORIG_HI = 5'b01000,
    PH_BACK_HI = 5'b10000
  } phase_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  header_type;
    logic [15:0] target_id;
    logic [31:0] read_data;
  } in_t;

  typedef struct packed {
    logic valid;
    in_t  data;
  } stage_t;

  typedef struct packed {
    logic [1:0]  kind_res;
    logic [15:0] target_id_res;
    logic [7:0]  offset;
    logic [31:0] write_data;
    logic [2:0]  bar_index;
    logic [63:0] bar_addr;
    logic [63:0] bar_size;
    logic        bar_is_io;
    logic        bar_is_wide;
    logic        bar_prefetch;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0]              cnt;
    res_t [MaxRes-1:0]       ent;
  } bundle_t;

  function automatic logic [7:0] slot_off(input logic [2:0] s);
    return BarBase + {3'b000, s, 2'b00};
  endfunction

  function automatic res_t mk_req(input logic is_wr, input logic [15:0] id,
                                  input logic [7:0] off, input logic [31:0] data);
    res_t r;
    r               = '0;
    r.kind_res      = is_wr ? RES_WRITE : RES_READ;
    r.target_id_res = id;
    r.offset        = off;
    r.write_data    = is_wr ? data : 32'h0;
    return r;
  endfunction

  function automatic res_t mk_next(input logic [15:0] id, input logic [2:0] s,
                                   input logic [2:0] cnt);
    res_t r;
    r = '0;
    if (s < cnt) begin
      r = mk_req(1'b0, id, slot_off(s), 32'h0);
    end else begin
      r.kind_res      = RES_DONE;
      r.target_id_res = id;
    end
    return r;
  endfunction

  function automatic res_t mk_rec(input logic [15:0] id, input logic [2:0] idx,
                                  input logic [63:0] addr, input logic [63:0] size,
                                  input logic io, input logic wide, input logic pf);
    res_t r;
    r               = '0;
    r.kind_res      = RES_RECORD;
    r.target_id_res = id;
    r.bar_index     = idx;
    r.bar_addr      = addr;
    r.bar_size      = size;
    r.bar_is_io     = io;
    r.bar_is_wide   = wide;
    r.bar_prefetch  = pf;
    return r;
  endfunction

endpackage

// ===== rtl/pbs_in_if.sv =====
// ----------------------------------------------------------------------------
// BAR sizing sequencer input channel
// Valid/ready channel carrying start and config read response beats.
// ----------------------------------------------------------------------------
interface pbs_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  header_type;
  logic [15:0] target_id;
  logic [31:0] read_data;

  modport source (output valid, kind, header_type, target_id, read_data, input ready);
  modport sink (input valid, kind, header_type, target_id, read_data, output ready);
endinterface

// ===== rtl/pbs_out_if.sv =====
// ----------------------------------------------------------------------------
// BAR sizing sequencer result channel
// Valid/ready channel carrying config requests, BAR records and done beats.
// ----------------------------------------------------------------------------
interface pbs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind_res;
  logic [15:0] target_id_res;
  logic [7:0]  offset;
  logic [31:0] write_data;
  logic [2:0]  bar_index;
  logic [63:0] bar_addr;
  logic [63:0] bar_size;
  logic        bar_is_io;
  logic        bar_is_wide;
  logic        bar_prefetch;
  logic        last;

  modport source (output valid, kind_res, target_id_res, offset, write_data, bar_index,
                  bar_addr, bar_size, bar_is_io, bar_is_wide, bar_prefetch, last,
                  input ready);
  modport sink (input valid, kind_res, target_id_res, offset, write_data, bar_index,
                bar_addr, bar_size, bar_is_io, bar_is_wide, bar_prefetch, last,
                output ready);
endinterface

// ===== rtl/pci_bar_sizing_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// PCI BAR sizing sequencer
// A start beat names a function and header type; the block then issues the
// config reads and writes that size each base address register, consumes the
// read responses and reports one record per implemented BAR, then a done beat.
// Each input beat is registered, handled in one pass of logic, and its up to
// three results are held in a result buffer that drains one beat per cycle
// while the receiver is ready. The first result of an input beat is offered
// once the input register has passed the beat to the step logic and the
// result buffer has registered its results. A new input beat is taken when
// the buffer is empty or in the cycle it hands out its final result.
// Responses that arrive while no probe is running produce no result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pci_bar_sizing_sequencer_unit import pbs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  pbs_in_if.sink    in_i,
  pbs_out_if.source out_o
);

  stage_t  stage;
  bundle_t bundle;
  logic    take;
  logic    free;

  pbs_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (take),
    .stage_o (stage)
  );

  pbs_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .stage_i  (stage),
    .free_i   (free),
    .take_o   (take),
    .bundle_o (bundle)
  );

  pbs_out_buf u_out_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (take),
    .bundle_i (bundle),
    .free_o   (free),
    .out_o    (out_o)
  );

  `PBS_ASSERT(a_take_needs_free, clk_i, rst_ni, take |-> (free && stage.valid))
  `PBS_ASSERT(a_accept_fills_stage, clk_i, rst_ni, (in_i.valid && in_i.ready) |=> stage.valid)
  `PBS_ASSERT(a_bundle_ends_last, clk_i, rst_ni,
    (take && (bundle.cnt != 2'd0)) |-> bundle.ent[bundle.cnt - 2'd1].last)
  `PBS_ASSERT_NEVER(a_start_one_read, clk_i, rst_ni,
    take && (stage.data.kind == KIND_START) && (bundle.cnt != 2'd1))

endmodule

// ===== rtl/pbs_in_stage.sv =====
// ----------------------------------------------------------------------------
// BAR sizing sequencer input register
// Holds one input beat until the step logic consumes it.
// ----------------------------------------------------------------------------
module pbs_in_stage import pbs_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  pbs_in_if.sink in_i,
  input  logic   take_i,
  output stage_t stage_o
);

  logic valid_q, valid_d;
  in_t  data_q;
  logic fire;

  assign in_i.ready = !valid_q || take_i;
  assign fire       = in_i.valid && in_i.ready;
  assign valid_d    = fire ? 1'b1 : (take_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      data_q <= '{kind: in_i.kind, header_type: in_i.header_type,
                  target_id: in_i.target_id, read_data: in_i.read_data};
    end
  end

  assign stage_o = '{valid: valid_q, data: data_q};

endmodule

// ===== rtl/pbs_step.sv =====
// ----------------------------------------------------------------------------
// BAR sizing sequencer step logic
// Probe state and the single-pass logic that turns one beat into its results.
// ----------------------------------------------------------------------------
module pbs_step import pbs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  stage_t  stage_i,
  input  logic    free_i,
  output logic    take_o,
  output bundle_t bundle_o
);

  phase_e      phase_q, phase_d;
  logic [2:0]  slot_q, slot_d;
  logic [2:0]  slot_cnt_q, slot_cnt_d;
  logic [15:0] func_id_q, func_id_d;
  logic [31:0] orig_low_q, orig_low_d;
  logic [31:0] probe_low_q, probe_low_d;
  logic [31:0] orig_high_q, orig_high_d;

  logic [31:0] data;
  logic [2:0]  slot_p1, slot_p2;
  logic [3:0]  slot_w;
  logic [7:0]  off_cur, off_hi;
  logic [31:0] io_back, io_neg, low_probe, low_neg;
  logic [63:0] io_size, n32_size, wide_mask, w_size;
  logic        is_wide, pf;

  assign take_o    = stage_i.valid && free_i;
  assign data      = stage_i.data.read_data;
  assign slot_p1   = slot_q + 3'd1;
  assign slot_p2   = slot_q + 3'd2;
  assign slot_w    = {1'b0, slot_q} + 4'd1;
  assign off_cur   = slot_off(slot_q);
  assign off_hi    = slot_off(slot_p1);
  assign io_back   = data & ~32'h3;
  assign io_neg    = ~io_back + 32'd1;
  assign io_size   = (io_back != 32'h0) ? {48'h0, io_neg[15:0]} : 64'h0;
  assign low_probe = data & ~32'hf;
  assign low_neg   = ~low_probe + 32'd1;
  assign n32_size  = (low_probe != 32'h0) ? {32'h0, low_neg} : 64'h0;
  assign wide_mask = {data, probe_low_q};
  assign w_size    = (wide_mask != 64'h0) ? (~wide_mask + 64'd1) : 64'h0;
  assign is_wide   = orig_low_q[2:1] == 2'b10;
  assign pf        = orig_low_q[3];

  always_comb begin
    phase_d     = phase_q;
    slot_d      = slot_q;
    slot_cnt_d  = slot_cnt_q;
    func_id_d   = func_id_q;
    orig_low_d  = orig_low_q;
    probe_low_d = probe_low_q;
    orig_high_d = orig_high_q;
    bundle_o    = '0;
    if (take_o) begin
      if (stage_i.data.kind == KIND_START) begin
        func_id_d       = stage_i.data.target_id;
        slot_cnt_d      = (stage_i.data.header_type[6:0] == 7'd0) ? 3'(NumSlots) : 3'd2;
        slot_d          = 3'd0;
        orig_low_d      = 32'h0;
        probe_low_d     = 32'h0;
        orig_high_d     = 32'h0;
        phase_d         = PH_ORIG;
        bundle_o.cnt    = 2'd1;
        bundle_o.ent[0] = mk_req(1'b0, stage_i.data.target_id, slot_off(3'd0), 32'h0);
      end else begin
        case (phase_q)
          PH_ORIG: begin
            orig_low_d = data;
            if (data == 32'h0) begin
              slot_d          = slot_p1;
              phase_d         = (slot_p1 < slot_cnt_q) ? PH_ORIG : PH_IDLE;
              bundle_o.cnt    = 2'd1;
              bundle_o.ent[0] = mk_next(func_id_q, slot_p1, slot_cnt_q);
            end else begin
              phase_d         = PH_BACK;
              bundle_o.cnt    = 2'd2;
              bundle_o.ent[0] = mk_req(1'b1, func_id_q, off_cur, 32'hffff_ffff);
              bundle_o.ent[1] = mk_req(1'b0, func_id_q, off_cur, 32'h0);
            end
          end
          PH_BACK: begin
            bundle_o.ent[0] = mk_req(1'b1, func_id_q, off_cur, orig_low_q);
            if (orig_low_q[0]) begin
              slot_d          = slot_p1;
              phase_d         = (slot_p1 < slot_cnt_q) ? PH_ORIG : PH_IDLE;
              bundle_o.cnt    = 2'd3;
              bundle_o.ent[1] = mk_rec(func_id_q, slot_q, {32'h0, orig_low_q & ~32'h3},
                                       io_size, 1'b1, 1'b0, 1'b0);
              bundle_o.ent[2] = mk_next(func_id_q, slot_p1, slot_cnt_q);
            end else begin
              probe_low_d = low_probe;
              if (is_wide && (slot_w < {1'b0, slot_cnt_q})) begin
                phase_d         = PH_ORIG_HI;
                bundle_o.cnt    = 2'd2;
                bundle_o.ent[1] = mk_req(1'b0, func_id_q, off_hi, 32'h0);
              end else begin
                slot_d          = slot_p1;
                phase_d         = (slot_p1 < slot_cnt_q) ? PH_ORIG : PH_IDLE;
                bundle_o.cnt    = 2'd3;
                bundle_o.ent[1] = mk_rec(func_id_q, slot_q, {32'h0, orig_low_q & ~32'hf},
                                         n32_size, 1'b0, is_wide, pf);
                bundle_o.ent[2] = mk_next(func_id_q, slot_p1, slot_cnt_q);
              end
            end
          end
          PH_ORIG_HI: begin
            orig_high_d     = data;
            phase_d         = PH_BACK_HI;
            bundle_o.cnt    = 2'd2;
            bundle_o.ent[0] = mk_req(1'b1, func_id_q, off_hi, 32'hffff_ffff);
            bundle_o.ent[1] = mk_req(1'b0, func_id_q, off_hi, 32'h0);
          end
          PH_BACK_HI: begin
            slot_d          = slot_p2;
            phase_d         = (slot_p2 < slot_cnt_q) ? PH_ORIG : PH_IDLE;
            bundle_o.cnt    = 2'd3;
            bundle_o.ent[0] = mk_req(1'b1, func_id_q, off_hi, orig_high_q);
            bundle_o.ent[1] = mk_rec(func_id_q, slot_q,
                                     {orig_high_q, orig_low_q & ~32'hf},
                                     w_size, 1'b0, 1'b1, pf);
            bundle_o.ent[2] = mk_next(func_id_q, slot_p2, slot_cnt_q);
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
      if (bundle_o.cnt != 2'd0) begin
        bundle_o.ent[bundle_o.cnt - 2'd1].last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      slot_q      <= 3'd0;
      slot_cnt_q  <= 3'd0;
      func_id_q   <= 16'h0;
      orig_low_q  <= 32'h0;
      probe_low_q <= 32'h0;
      orig_high_q <= 32'h0;
    end else begin
      phase_q     <= phase_d;
      slot_q      <= slot_d;
      slot_cnt_q  <= slot_cnt_d;
      func_id_q   <= func_id_d;
      orig_low_q  <= orig_low_d;
      probe_low_q <= probe_low_d;
      orig_high_q <= orig_high_d;
    end
  end

endmodule

// ===== rtl/pbs_out_buf.sv =====
// ----------------------------------------------------------------------------
// BAR sizing sequencer result buffer
// Registers the results of one item and hands them out one beat per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module pbs_out_buf import pbs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  bundle_t    bundle_i,
  output logic       free_o,
  pbs_out_if.source  out_o
);

  res_t [MaxRes-1:0] buf_q;
  logic [1:0]        cnt_q, cnt_d;
  logic [1:0]        idx_q, idx_d;
  logic              fire, last_beat;
  res_t              cur;

  assign cur       = buf_q[idx_q];
  assign fire      = out_o.valid && out_o.ready;
  assign last_beat = (idx_q + 2'd1) == cnt_q;
  assign free_o    = (cnt_q == 2'd0) || (fire && last_beat);

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (load_i) begin
      cnt_d = bundle_i.cnt;
      idx_d = 2'd0;
    end else if (fire) begin
      if (last_beat) begin
        cnt_d = 2'd0;
        idx_d = 2'd0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      idx_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q <= bundle_i.ent;
    end
  end

  assign out_o.valid         = cnt_q != 2'd0;
  assign out_o.kind_res      = cur.kind_res;
  assign out_o.target_id_res = cur.target_id_res;
  assign out_o.offset        = cur.offset;
  assign out_o.write_data    = cur.write_data;
  assign out_o.bar_index     = cur.bar_index;
  assign out_o.bar_addr      = cur.bar_addr;
  assign out_o.bar_size      = cur.bar_size;
  assign out_o.bar_is_io     = cur.bar_is_io;
  assign out_o.bar_is_wide   = cur.bar_is_wide;
  assign out_o.bar_prefetch  = cur.bar_prefetch;
  assign out_o.last          = cur.last;

endmodule

// ===== tb/sv/pci_bar_sizing_sequencer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// PCI BAR sizing sequencer testbench
// Drives start and config read response beats into the sequencer and checks
// every config request, BAR record and done beat it returns against a
// cycle-free model of the sizing sequence. A directed set of devices comes
// first, then randomly built devices with random BAR layouts, some probes cut
// short by a new start and some stray responses, under random input gaps,
// receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module pci_bar_sizing_sequencer_unit_tb import pbs_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LimitCycles = 200000;
  localparam int unsigned HoldStart   = 150;
  localparam int unsigned HoldLen     = 400;
  localparam int unsigned TailCycles  = 20;
  localparam int          RandItems   = 132;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  pbs_in_if  in_if();
  pbs_out_if out_if();

  pci_bar_sizing_sequencer_unit u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  in_t         stim_q[$];
  res_t        bar_exp_q[$];
  bit          in_taken;
  int          errors;
  int unsigned cycles;
  int          burst_left = 1;
  int          gap_left;
  int unsigned rx_cycles;
  int          stall_mode;
  int          mode_left;

  phase_e      pr_phase    = PH_IDLE;
  logic [2:0]  pr_slot     = '0;
  logic [2:0]  pr_count    = '0;
  logic [15:0] pr_fid      = '0;
  logic [31:0] pr_orig_lo  = '0;
  logic [31:0] pr_probe_lo = '0;
  logic [31:0] pr_orig_hi  = '0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] cfg_off(logic [2:0] s);
    return BarBase + {3'b000, s, 2'b00};
  endfunction

  function automatic res_t blank_beat(res_kind_e k);
    res_t r;
    r               = '0;
    r.kind_res      = k;
    r.target_id_res = pr_fid;
    return r;
  endfunction

  function automatic res_t cfg_access(logic wr, logic [7:0] off, logic [31:0] data);
    res_t r;
    r            = blank_beat(wr ? RES_WRITE : RES_READ);
    r.offset     = off;
    r.write_data = wr ? data : 32'h0;
    return r;
  endfunction

  function automatic res_t bar_record(logic [63:0] addr, logic [63:0] size,
                                      logic io, logic wide, logic pf);
    res_t r;
    r              = blank_beat(RES_RECORD);
    r.bar_index    = pr_slot;
    r.bar_addr     = addr;
    r.bar_size     = size;
    r.bar_is_io    = io;
    r.bar_is_wide  = wide;
    r.bar_prefetch = pf;
    return r;
  endfunction

  function automatic res_t step_slot(logic [2:0] step);
    pr_slot = pr_slot + step;
    if (pr_slot < pr_count) begin
      pr_phase = PH_ORIG;
      return cfg_access(1'b0, cfg_off(pr_slot), 32'h0);
    end
    pr_phase = PH_IDLE;
    return blank_beat(RES_DONE);
  endfunction

  // Works out the beats that one accepted input beat causes.
  function automatic void size_predict(in_t b);
    res_t        rb[3];
    int          n;
    logic [31:0] d;
    logic [31:0] back;
    logic [15:0] io_size;
    logic [63:0] mask;
    logic [63:0] size;
    logic        wide;
    n = 0;
    d = b.read_data;
    if (b.kind == KIND_START) begin
      pr_fid      = b.target_id;
      pr_count    = (b.header_type[6:0] == 7'h0) ? 3'(NumSlots) : 3'd2;
      pr_slot     = '0;
      pr_orig_lo  = '0;
      pr_probe_lo = '0;
      pr_orig_hi  = '0;
      pr_phase    = PH_ORIG;
      rb[n++]     = cfg_access(1'b0, cfg_off(3'd0), 32'h0);
    end else begin
      case (pr_phase)
        PH_ORIG: begin
          pr_orig_lo = d;
          if (d == 32'h0) begin
            rb[n++] = step_slot(3'd1);
          end else begin
            pr_phase = PH_BACK;
            rb[n++]  = cfg_access(1'b1, cfg_off(pr_slot), 32'hffff_ffff);
            rb[n++]  = cfg_access(1'b0, cfg_off(pr_slot), 32'h0);
          end
        end
        PH_BACK: begin
          rb[n++] = cfg_access(1'b1, cfg_off(pr_slot), pr_orig_lo);
          if (pr_orig_lo[0]) begin
            back    = d & ~32'h3;
            io_size = 16'(~back + 32'd1);
            size    = (back != 32'h0) ? {48'h0, io_size} : 64'h0;
            rb[n++] = bar_record({32'h0, pr_orig_lo & ~32'h3}, size, 1'b1, 1'b0, 1'b0);
            rb[n++] = step_slot(3'd1);
          end else begin
            wide        = (pr_orig_lo[2:1] == 2'b10);
            pr_probe_lo = d & ~32'hf;
            if (wide && (pr_slot + 1 < pr_count)) begin
              pr_phase = PH_ORIG_HI;
              rb[n++]  = cfg_access(1'b0, cfg_off(pr_slot + 3'd1), 32'h0);
            end else begin
              mask    = {32'hffff_ffff, pr_probe_lo};
              size    = (pr_probe_lo != 32'h0) ? ~mask + 64'd1 : 64'h0;
              rb[n++] = bar_record({32'h0, pr_orig_lo & ~32'hf}, size, 1'b0, wide,
                                   pr_orig_lo[3]);
              rb[n++] = step_slot(3'd1);
            end
          end
        end
        PH_ORIG_HI: begin
          pr_orig_hi = d;
          pr_phase   = PH_BACK_HI;
          rb[n++]    = cfg_access(1'b1, cfg_off(pr_slot + 3'd1), 32'hffff_ffff);
          rb[n++]    = cfg_access(1'b0, cfg_off(pr_slot + 3'd1), 32'h0);
        end
        PH_BACK_HI: begin
          mask    = {d, pr_probe_lo};
          size    = (pr_probe_lo != 32'h0 || d != 32'h0) ? ~mask + 64'd1 : 64'h0;
          rb[n++] = cfg_access(1'b1, cfg_off(pr_slot + 3'd1), pr_orig_hi);
          rb[n++] = bar_record({pr_orig_hi, pr_orig_lo & ~32'hf}, size, 1'b0, 1'b1,
                               pr_orig_lo[3]);
          rb[n++] = step_slot(3'd2);
        end
        default: begin
          pr_phase = PH_IDLE;
        end
      endcase
    end
    if (n > 0) begin
      rb[n-1].last = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      bar_exp_q.push_back(rb[i]);
    end
  endfunction

  function automatic void check_field(string fname, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
      errors++;
    end
  endfunction

  task automatic add_start(logic [7:0] ht, logic [15:0] id);
    in_t b;
    b.kind        = KIND_START;
    b.header_type = ht;
    b.target_id   = id;
    b.read_data   = $urandom;
    stim_q.push_back(b);
  endtask

  task automatic add_resp(logic [31:0] data);
    in_t b;
    b.kind        = KIND_RESP;
    b.header_type = 8'($urandom);
    b.target_id   = 16'($urandom);
    b.read_data   = data;
    stim_q.push_back(b);
  endtask

  // Builds one device with a random BAR layout and answers its probe, sometimes cutting the answers short.
  task automatic add_device(inout int made);
    logic [31:0] resp_q[$];
    logic [31:0] orig;
    logic [31:0] back;
    logic [7:0]  ht;
    int          cnt;
    int          s;
    int          keep;
    bit          cut;
    ht = 8'($urandom);
    if ($urandom_range(0, 1) == 0) begin
      ht[6:0] = 7'h0;
    end
    cnt = (ht[6:0] == 7'h0) ? NumSlots : 2;
    s   = 0;
    cut = 1'b0;
    while (s < cnt) begin
      case ($urandom_range(0, 5))
        0:       orig = 32'h0;
        1:       orig = ($urandom & 32'h0000_fffc) | 32'h1;
        2:       orig = ($urandom & ~32'hf) | ($urandom & 32'h8);
        3, 4:    orig = ($urandom & ~32'hf) | ($urandom & 32'h8) | 32'h4;
        default: orig = $urandom;
      endcase
      resp_q.push_back(orig);
      if (orig == 32'h0) begin
        s++;
      end else begin
        case ($urandom_range(0, 7))
          0:       back = 32'h0;
          1:       back = $urandom;
          default: back = (32'hffff_ffff << $urandom_range(2, 31)) | (orig & 32'hf);
        endcase
        resp_q.push_back(back);
        if (!orig[0] && orig[2:1] == 2'b10 && s + 1 < cnt) begin
          resp_q.push_back(($urandom_range(0, 2) == 0) ? 32'h0 : $urandom);
          case ($urandom_range(0, 3))
            0:       resp_q.push_back(32'h0);
            1:       resp_q.push_back(32'hffff_ffff);
            2:       resp_q.push_back($urandom);
            default: resp_q.push_back(32'hffff_ffff << $urandom_range(0, 31));
          endcase
          s += 2;
        end else begin
          s++;
        end
      end
    end
    if ($urandom_range(0, 6) == 0) begin
      cut  = 1'b1;
      keep = $urandom_range(0, resp_q.size() - 1);
      while (resp_q.size() > keep) begin
        void'(resp_q.pop_back());
      end
    end
    add_start(ht, 16'($urandom));
    made++;
    foreach (resp_q[i]) begin
      add_resp(resp_q[i]);
    end
    made += resp_q.size();
    if (!cut && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) add_resp($urandom);
    end
  endtask

  initial begin
    int made;
    in_if.valid       = 1'b0;
    in_if.kind        = KIND_START;
    in_if.header_type = '0;
    in_if.target_id   = '0;
    in_if.read_data   = '0;
    out_if.ready      = 1'b0;

    // A response with no probe running is dropped.
    add_resp(32'hffff_ffff);
    // Six slots: I/O, empty, 64-bit prefetchable, 32-bit, 64-bit in the last slot.
    add_start(8'h00, 16'hffff);
    add_resp(32'h0000_ff01);
    add_resp(32'hffff_ff01);
    add_resp(32'h0000_0000);
    add_resp(32'hf000_000c);
    add_resp(32'hfff0_000c);
    add_resp(32'h0000_0001);
    add_resp(32'hffff_ffff);
    add_resp(32'hfebf_0000);
    add_resp(32'hffff_0000);
    add_resp(32'he000_0004);
    add_resp(32'hffff_fff4);
    // Two slots, both reading back zero.
    add_start(8'hff, 16'h0000);
    add_resp(32'hffff_ffff);
    add_resp(32'h0000_0000);
    add_resp(32'h0000_0008);
    add_resp(32'h0000_0000);
    // A 64-bit BAR of size zero, then a new start cuts the probe short.
    add_start(8'h80, 16'h1234);
    add_resp(32'h8000_0004);
    add_resp(32'h0000_0004);
    add_resp(32'hffff_ffff);
    add_resp(32'h0000_0000);
    add_start(8'h01, 16'habcd);
    add_resp(32'h0000_0000);
    add_resp(32'h0000_0000);

    made = 0;
    while (made < RandItems) begin
      add_device(made);
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (stim_q.size() == 0);
    while (bar_exp_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (TailCycles) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  always @(negedge clk) begin : driver
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!(in_if.valid && !in_taken)) begin
      in_taken = 1'b0;
      if (gap_left > 0 || stim_q.size() == 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end
        in_if.valid <= 1'b0;
      end else begin
        in_if.kind        <= stim_q[0].kind;
        in_if.header_type <= stim_q[0].header_type;
        in_if.target_id   <= stim_q[0].target_id;
        in_if.read_data   <= stim_q[0].read_data;
        in_if.valid       <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  always @(negedge clk) begin : rx_stall
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      rx_cycles++;
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end
      if (rx_cycles >= HoldStart && rx_cycles < HoldStart + HoldLen) begin
        out_if.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= ($urandom_range(0, 9) < 7);
          2:       out_if.ready <= ((rx_cycles % 4) == 0);
          default: out_if.ready <= ($urandom_range(0, 9) < 2);
        endcase
      end
    end
  end

  always @(posedge clk) begin : monitor
    res_t got;
    res_t want;
    in_t  beat;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        got.kind_res      = out_if.kind_res;
        got.target_id_res = out_if.target_id_res;
        got.offset        = out_if.offset;
        got.write_data    = out_if.write_data;
        got.bar_index     = out_if.bar_index;
        got.bar_addr      = out_if.bar_addr;
        got.bar_size      = out_if.bar_size;
        got.bar_is_io     = out_if.bar_is_io;
        got.bar_is_wide   = out_if.bar_is_wide;
        got.bar_prefetch  = out_if.bar_prefetch;
        got.last          = out_if.last;
        if (bar_exp_q.size() == 0) begin
          $display("%0t ns: unexpected beat, expected none, actual kind %0d", $time,
                   got.kind_res);
          errors++;
        end else begin
          want = bar_exp_q.pop_front();
          check_field("kind_res", want.kind_res, got.kind_res);
          check_field("target_id_res", want.target_id_res, got.target_id_res);
          check_field("offset", want.offset, got.offset);
          check_field("write_data", want.write_data, got.write_data);
          check_field("bar_index", want.bar_index, got.bar_index);
          check_field("bar_addr", want.bar_addr, got.bar_addr);
          check_field("bar_size", want.bar_size, got.bar_size);
          check_field("bar_is_io", want.bar_is_io, got.bar_is_io);
          check_field("bar_is_wide", want.bar_is_wide, got.bar_is_wide);
          check_field("bar_prefetch", want.bar_prefetch, got.bar_prefetch);
          check_field("last", want.last, got.last);
        end
      end
      if (in_if.valid && in_if.ready) begin
        beat.kind        = in_if.kind;
        beat.header_type = in_if.header_type;
        beat.target_id   = in_if.target_id;
        beat.read_data   = in_if.read_data;
        size_predict(beat);
        void'(stim_q.pop_front());
        in_taken = 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles > LimitCycles) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
